// ===== hw/rtl/rpo_pkg.sv =====
// Package: shared constants, item codes and helpers for the rectangle overlay unit.
`timescale 1ns / 1ps

package rpo_pkg;

  localparam int DefSlotCount  = 5;
  localparam int DefSideLength = 150;

  localparam int PosW   = 11;
  localparam int DeltaW = 12;
  localparam int EdgeW  = 16;
  localparam int SlotW  = 3;
  // Compare width: holds an edge plus the largest side without wrap.
  localparam int CmpW   = EdgeW + 2;

  localparam int ResetBase = 50;
  localparam int ResetStep = 50;

  localparam logic KindPixel = 1'b0;
  localparam logic KindFrame = 1'b1;

  typedef struct packed {
    logic             covered_odd;
    logic             highlight;
    logic             picked;
    logic [SlotW-1:0] picked_slot;
  } result_t;

  // Clamp a one-bit-grown sum back to the signed edge range.
  function automatic logic signed [EdgeW-1:0] sat_edge(input logic signed [EdgeW:0] v);
    logic signed [EdgeW-1:0] r;
    if (v[EdgeW] != v[EdgeW-1]) begin
      r = v[EdgeW] ? {1'b1, {(EdgeW-1){1'b0}}} : {1'b0, {(EdgeW-1){1'b1}}};
    end else begin
      r = v[EdgeW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rpo_calc.sv =====
// Combinational hit test, parity, first-hit pick and raise/move of the squares.
`timescale 1ns / 1ps

module rpo_calc import rpo_pkg::*; #(
  parameter int SLOT_COUNT  = DefSlotCount,
  parameter int SIDE_LENGTH = DefSideLength
) (
  input  logic                    kind_i,
  input  logic [PosW-1:0]         pos_x_i,
  input  logic [PosW-1:0]         pos_y_i,
  input  logic                    button_down_i,
  input  logic signed [DeltaW-1:0] delta_x_i,
  input  logic signed [DeltaW-1:0] delta_y_i,
  input  logic signed [EdgeW-1:0] left_i [SLOT_COUNT],
  input  logic signed [EdgeW-1:0] top_i  [SLOT_COUNT],
  input  logic                    drag_i,
  output logic signed [EdgeW-1:0] left_o [SLOT_COUNT],
  output logic signed [EdgeW-1:0] top_o  [SLOT_COUNT],
  output logic                    edge_we_o,
  output result_t                 res_o
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0]    hit_vec;
  logic                     hit_any;
  logic [IdxW-1:0]          hit_idx;
  logic signed [CmpW-1:0]   x_ext, y_ext;
  logic signed [EdgeW:0]    sum_x, sum_y;
  logic                     is_frame;

  assign x_ext = signed'(CmpW'(pos_x_i));
  assign y_ext = signed'(CmpW'(pos_y_i));

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_hit
    logic signed [CmpW-1:0] l_ext, t_ext;
    assign l_ext = CmpW'(left_i[g]);
    assign t_ext = CmpW'(top_i[g]);
    assign hit_vec[g] = (x_ext >= l_ext) && (x_ext < l_ext + CmpW'(SIDE_LENGTH)) &&
                        (y_ext >= t_ext) && (y_ext < t_ext + CmpW'(SIDE_LENGTH));
  end

  // Lowest slot wins: scan from the back so the front hit overrides.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign sum_x = (EdgeW+1)'(left_i[hit_idx]) + (EdgeW+1)'(delta_x_i);
  assign sum_y = (EdgeW+1)'(top_i[hit_idx]) + (EdgeW+1)'(delta_y_i);

  // Raise: picked square goes to the front, the ones ahead of it step back.
  always_comb begin
    left_o[0] = sat_edge(sum_x);
    top_o[0]  = sat_edge(sum_y);
    for (int i = 1; i < SLOT_COUNT; i++) begin
      if (IdxW'(i) <= hit_idx) begin
        left_o[i] = left_i[i-1];
        top_o[i]  = top_i[i-1];
      end else begin
        left_o[i] = left_i[i];
        top_o[i]  = top_i[i];
      end
    end
  end

  assign is_frame  = (kind_i == KindFrame);
  assign edge_we_o = is_frame && button_down_i && hit_any;

  always_comb begin
    res_o.covered_odd = !is_frame && (^hit_vec);
    res_o.highlight   = is_frame ? edge_we_o : drag_i;
    res_o.picked      = edge_we_o;
    res_o.picked_slot = edge_we_o ? SlotW'(hit_idx) : '0;
  end

endmodule

// ===== hw/rtl/rect_parity_overlay_with_raise_unit.sv =====
// Top level: input register, square store, result register and handshake.
`timescale 1ns / 1ps

// Even-odd overlay of a stack of equal squares with click-to-raise drag.
// Input channel: in_valid_i / in_stall_o with fields kind_i, pos_x_i, pos_y_i,
//   button_down_i, delta_x_i, delta_y_i. kind 0 is a pixel query, 1 a pointer
//   frame event. A beat is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with covered_odd_o, highlight_o,
//   picked_o, picked_slot_o. Every input beat gives exactly one output beat.
// Path: input register holds a taken beat, result register holds its result.
// Throughput: one beat per cycle while out_stall_i holds no result; the hit
//   compares of all squares, the first-hit pick and the raise/move update sit
//   between the two registers, and each beat sees the squares as left by the
//   beat before it.
// Stall: while out_stall_i holds a result, the input register still takes
//   one more beat; after that in_stall_o rises until the result drains.
// Reset (rst_ni low, asynchronous): both stages empty, drag flag cleared,
//   square i placed with its left and top edges at 50 + 50 * i.

module rect_parity_overlay_with_raise_unit import rpo_pkg::*; #(
  parameter int SLOT_COUNT  = DefSlotCount,
  parameter int SIDE_LENGTH = DefSideLength
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [PosW-1:0]          pos_x_i,
  input  logic [PosW-1:0]          pos_y_i,
  input  logic                     button_down_i,
  input  logic signed [DeltaW-1:0] delta_x_i,
  input  logic signed [DeltaW-1:0] delta_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     covered_odd_o,
  output logic                     highlight_o,
  output logic                     picked_o,
  output logic [SlotW-1:0]         picked_slot_o
);

  logic                     s1_valid_q;
  logic                     kind_q;
  logic [PosW-1:0]          pos_x_q, pos_y_q;
  logic                     button_q;
  logic signed [DeltaW-1:0] delta_x_q, delta_y_q;

  logic                     out_valid_q;
  result_t                  res_q, res_d;

  logic signed [EdgeW-1:0]  left_q [SLOT_COUNT];
  logic signed [EdgeW-1:0]  top_q  [SLOT_COUNT];
  logic signed [EdgeW-1:0]  left_d [SLOT_COUNT];
  logic signed [EdgeW-1:0]  top_d  [SLOT_COUNT];
  logic                     drag_q;
  logic                     edge_we;

  logic advance, s1_load, fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      kind_q    <= kind_i;
      pos_x_q   <= pos_x_i;
      pos_y_q   <= pos_y_i;
      button_q  <= button_down_i;
      delta_x_q <= delta_x_i;
      delta_y_q <= delta_y_i;
    end
  end

  rpo_calc #(
    .SLOT_COUNT  (SLOT_COUNT),
    .SIDE_LENGTH (SIDE_LENGTH)
  ) u_calc (
    .kind_i        (kind_q),
    .pos_x_i       (pos_x_q),
    .pos_y_i       (pos_y_q),
    .button_down_i (button_q),
    .delta_x_i     (delta_x_q),
    .delta_y_i     (delta_y_q),
    .left_i        (left_q),
    .top_i         (top_q),
    .drag_i        (drag_q),
    .left_o        (left_d),
    .top_o         (top_d),
    .edge_we_o     (edge_we),
    .res_o         (res_d)
  );

  // Square store and drag flag advance together with the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        left_q[i] <= EdgeW'(ResetBase + ResetStep * i);
        top_q[i]  <= EdgeW'(ResetBase + ResetStep * i);
      end
    end else if (fire) begin
      drag_q <= res_d.highlight;
      if (edge_we) begin
        left_q <= left_d;
        top_q  <= top_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign covered_odd_o = res_q.covered_odd;
  assign highlight_o   = res_q.highlight;
  assign picked_o      = res_q.picked;
  assign picked_slot_o = res_q.picked_slot;

endmodule

// ===== tb/sv/rect_parity_overlay_with_raise_unit_tb.sv =====
// Testbench: directed and random beats for the square overlay unit, checked against a predictor.
`timescale 1ns / 1ps

module rect_parity_overlay_with_raise_unit_tb;
  import rpo_pkg::*;

  localparam int SlotCount  = DefSlotCount;
  localparam int SideLength = DefSideLength;
  localparam int RandomBeats = 1800;
  localparam int LongHold    = 64;
  localparam int IdleLimit   = 2000;
  localparam int MaxPrinted  = 40;

  localparam int StallNone     = 0;
  localparam int StallLight    = 1;
  localparam int StallHeavy    = 2;
  localparam int StallPeriodic = 3;

  typedef struct packed {
    logic                     kind;
    logic [PosW-1:0]          pos_x;
    logic [PosW-1:0]          pos_y;
    logic                     button_down;
    logic [DeltaW-1:0]        delta_x;
    logic [DeltaW-1:0]        delta_y;
  } beat_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i = KindPixel;
  logic [PosW-1:0]          pos_x_i = '0;
  logic [PosW-1:0]          pos_y_i = '0;
  logic                     button_down_i = 1'b0;
  logic signed [DeltaW-1:0] delta_x_i = '0;
  logic signed [DeltaW-1:0] delta_y_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     covered_odd_o;
  logic                     highlight_o;
  logic                     picked_o;
  logic [SlotW-1:0]         picked_slot_o;

  // Predictor state: square stack, front first.
  logic signed [EdgeW-1:0] sq_left [SlotCount];
  logic signed [EdgeW-1:0] sq_top  [SlotCount];
  logic                    drag_on;

  result_t pending_overlay_results [$];
  result_t want_res;
  int      err_count = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      sent_beats = 0;

  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      stall_mode = StallNone;
  int      mode_left = 0;
  int      pattern_cnt = 0;

  rect_parity_overlay_with_raise_unit #(
    .SLOT_COUNT (SlotCount),
    .SIDE_LENGTH(SideLength)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .button_down_i(button_down_i),
    .delta_x_i    (delta_x_i),
    .delta_y_i    (delta_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .covered_odd_o(covered_odd_o),
    .highlight_o  (highlight_o),
    .picked_o     (picked_o),
    .picked_slot_o(picked_slot_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_overlay_model();
    int i;
    for (i = 0; i < SlotCount; i++) begin
      sq_left[i] = EdgeW'(ResetBase + ResetStep * i);
      sq_top[i]  = EdgeW'(ResetBase + ResetStep * i);
    end
    drag_on = 1'b0;
  endfunction

  function automatic bit square_holds(input int s, input int x, input int y);
    int l;
    int t;
    l = int'(sq_left[s]);
    t = int'(sq_top[s]);
    return x >= l && x < l + SideLength && y >= t && y < t + SideLength;
  endfunction

  function automatic int first_hit(input int x, input int y);
    int i;
    for (i = 0; i < SlotCount; i++) begin
      if (square_holds(i, x, y)) return i;
    end
    return -1;
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Apply one beat to the square stack and return the result it must produce.
  function automatic result_t predict_overlay(input beat_t b);
    result_t r;
    int px;
    int py;
    int cnt;
    int hit;
    int i;
    int l;
    int t;
    px = int'(b.pos_x);
    py = int'(b.pos_y);
    r = '0;
    if (b.kind == KindPixel) begin
      cnt = 0;
      for (i = 0; i < SlotCount; i++) begin
        if (square_holds(i, px, py)) cnt++;
      end
      r.covered_odd = cnt[0];
    end else begin
      drag_on = 1'b0;
      if (b.button_down) begin
        hit = first_hit(px, py);
        if (hit >= 0) begin
          l = int'(sq_left[hit]);
          t = int'(sq_top[hit]);
          for (i = hit; i >= 1; i--) begin
            sq_left[i] = sq_left[i-1];
            sq_top[i]  = sq_top[i-1];
          end
          sq_left[0] = EdgeW'(clamp_int(l + int'($signed(b.delta_x)), -32768, 32767));
          sq_top[0]  = EdgeW'(clamp_int(t + int'($signed(b.delta_y)), -32768, 32767));
          drag_on = 1'b1;
          r.picked = 1'b1;
          r.picked_slot = SlotW'(hit);
        end
      end
    end
    r.highlight = drag_on;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // Pick a point inside square s, or on or just outside its edges, clamped to the screen.
  function automatic void aim_at_square(input int s, input bit in_square, output int x,
                                        output int y);
    int off [4];
    off[0] = -1;
    off[1] = 0;
    off[2] = SideLength - 1;
    off[3] = SideLength;
    if (in_square || $urandom_range(0, 1)) begin
      x = int'(sq_left[s]) + int'($urandom_range(0, SideLength - 1));
      y = int'(sq_top[s]) + int'($urandom_range(0, SideLength - 1));
    end else begin
      x = int'(sq_left[s]) + off[$urandom_range(0, 3)];
      y = int'(sq_top[s]) + off[$urandom_range(0, 3)];
    end
    x = clamp_int(x, 0, 2047);
    y = clamp_int(y, 0, 2047);
  endfunction

  // Delta that keeps a dragged edge where the pointer can still reach it.
  function automatic int steer_delta(input int edge_pos);
    int d;
    if ($urandom_range(0, 1)) begin
      d = int'($urandom_range(0, 64)) - 32;
      if (edge_pos > 1800 && d > 0) d = -d;
      if (edge_pos < 0 && d < 0) d = -d;
    end else begin
      d = (int'($urandom_range(0, 2130)) - 140) - edge_pos;
    end
    return clamp_int(d, -2048, 2047);
  endfunction

  function automatic beat_t random_overlay_beat();
    beat_t b;
    int r;
    int s;
    int x;
    int y;
    int h;
    b.kind        = KindPixel;
    b.pos_x       = PosW'($urandom);
    b.pos_y       = PosW'($urandom);
    b.button_down = 1'($urandom);
    b.delta_x     = DeltaW'($urandom);
    b.delta_y     = DeltaW'($urandom);
    r = $urandom_range(0, 99);
    s = $urandom_range(0, SlotCount - 1);
    if (r < 45) begin
      aim_at_square(s, 1'b0, x, y);
      b.pos_x = PosW'(x);
      b.pos_y = PosW'(y);
    end else if (r < 55) begin
      b.kind = KindPixel;
    end else if (r < 85) begin
      aim_at_square(s, 1'b1, x, y);
      b.kind = KindFrame;
      b.button_down = 1'b1;
      b.pos_x = PosW'(x);
      b.pos_y = PosW'(y);
    end else if (r < 92) begin
      b.kind = KindFrame;
      b.button_down = 1'b0;
    end else begin
      b.kind = KindFrame;
      b.button_down = 1'b1;
    end
    if (b.kind == KindFrame && b.button_down) begin
      h = first_hit(int'(b.pos_x), int'(b.pos_y));
      if (h >= 0) begin
        b.delta_x = DeltaW'(steer_delta(int'(sq_left[h])));
        b.delta_y = DeltaW'(steer_delta(int'(sq_top[h])));
      end
    end
    return b;
  endfunction

  // ---------------------------------------------------------------- driver

  // Offer one beat at the falling edge and hold it until taken.
  task automatic send_beat(input beat_t b);
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    kind_i        = b.kind;
    pos_x_i       = b.pos_x;
    pos_y_i       = b.pos_y;
    button_down_i = b.button_down;
    delta_x_i     = b.delta_x;
    delta_y_i     = b.delta_y;
    do @(posedge clk_i); while (in_stall_o);
    pending_overlay_results.push_back(predict_overlay(b));
    sent_beats++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_pixel(input int x, input int y);
    beat_t b;
    b = random_overlay_beat();
    b.kind  = KindPixel;
    b.pos_x = PosW'(x);
    b.pos_y = PosW'(y);
    send_beat(b);
  endtask

  task automatic send_frame(input int x, input int y, input bit btn, input int dx,
                            input int dy);
    beat_t b;
    b.kind        = KindFrame;
    b.pos_x       = PosW'(x);
    b.pos_y       = PosW'(y);
    b.button_down = btn;
    b.delta_x     = DeltaW'(dx);
    b.delta_y     = DeltaW'(dy);
    send_beat(b);
  endtask

  task automatic send_random_burst(input int n);
    repeat (n) send_beat(random_overlay_beat());
  endtask

  task automatic wait_all_results();
    pause_sender(1);
    while (pending_overlay_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(negedge clk_i) begin
    pattern_cnt++;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold - 1;
      out_stall_i = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(StallNone, StallPeriodic);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        StallNone:  out_stall_i = 1'b0;
        StallLight: out_stall_i = ($urandom_range(0, 99) < 20);
        StallHeavy: out_stall_i = ($urandom_range(0, 99) < 65);
        default:    out_stall_i = (pattern_cnt % 5 < 2);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("mismatch on result %0d, %s: got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_overlay_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want_res = pending_overlay_results.pop_front();
        if (covered_odd_o !== want_res.covered_odd)
          report_mismatch("covered_odd", covered_odd_o, want_res.covered_odd);
        if (highlight_o !== want_res.highlight)
          report_mismatch("highlight", highlight_o, want_res.highlight);
        if (picked_o !== want_res.picked)
          report_mismatch("picked", picked_o, want_res.picked);
        if (picked_slot_o !== want_res.picked_slot)
          report_mismatch("picked_slot", picked_slot_o, want_res.picked_slot);
      end
      results_seen++;
    end
  end

  // End the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_layout();
    send_pixel(0, 0);
    send_pixel(50, 50);
    send_pixel(120, 120);
    send_pixel(199, 199);
    send_pixel(2047, 2047);
    send_pixel(0, 2047);
    send_pixel(2047, 0);
  endtask

  task automatic test_raise_and_release();
    // Back square only: raise it from the last slot to the front.
    send_frame(380, 380, 1'b1, 5, -3);
    send_pixel(300, 300);
    send_frame(60, 60, 1'b0, 7, 7);
    send_frame(2047, 0, 1'b1, 100, 100);
    send_pixel(2047, 0);
  endtask

  task automatic test_delta_extremes();
    int x;
    int y;
    x = int'(sq_left[0]);
    y = int'(sq_top[0]);
    send_frame(x, y, 1'b1, -100 - x, -100 - y);
    send_frame(0, 0, 1'b1, 2047, 2047);
    send_frame(2000, 2000, 1'b1, -2048, -2048);
    send_pixel(0, 0);
    send_frame(0, 0, 1'b1, 300, 300);
  endtask

  task automatic test_backpressure_fill();
    hold_req = 1'b1;
    send_random_burst(40);
  endtask

  task automatic test_drain_pause();
    send_random_burst(30);
    wait_all_results();
    pause_sender($urandom_range(1, 10));
    send_random_burst(30);
  endtask

  task automatic test_random_mix();
    int target;
    int burst;
    target = sent_beats + RandomBeats;
    while (sent_beats < target) begin
      burst = $urandom_range(1, 40);
      send_random_burst(burst);
      if ($urandom_range(0, 99) < 70) pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    reset_overlay_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_layout();
    test_raise_and_release();
    test_delta_extremes();
    test_backpressure_fill();
    test_drain_pause();
    test_random_mix();

    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (pending_overlay_results.size() != 0) report_mismatch("results left over", 0, 0);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rpo_pkg.sv
hw/rtl/rpo_calc.sv
hw/rtl/rect_parity_overlay_with_raise_unit.sv
tb/sv/rect_parity_overlay_with_raise_unit_tb.sv
